// ===== rtl/led_pattern_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// led_pattern_engine_unit_defines : assertion macros
// Shorthand for clocked implication checks, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_ENGINE_UNIT_DEFINES_SVH
`define LED_PATTERN_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LPE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpe check failed: same-cycle implication");

// Next-cycle implication.
`define LPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpe check failed: next-cycle implication");

`endif

// ===== rtl/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types, codes and helpers of the LED pattern engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

  localparam int NUM_LEDS = 4;
  // Lit vector padded so the 4-bit result can always be sliced from it.
  localparam int LIT_W    = (NUM_LEDS > 4) ? NUM_LEDS : 4;

  // Event codes
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_SET_PAT = 2'd1;
  localparam logic [1:0] ACT_SET_DIR = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Pattern codes; 6 and 7 are stored but hold the LED on a tick (lifetime expiry still applies)
  localparam logic [2:0] PAT_OFF   = 3'd0;
  localparam logic [2:0] PAT_ON    = 3'd1;
  localparam logic [2:0] PAT_SLOW  = 3'd2;
  localparam logic [2:0] PAT_FAST  = 3'd3;
  localparam logic [2:0] PAT_PULSE = 3'd4;
  localparam logic [2:0] PAT_HEART = 3'd5;

  localparam logic [31:0] SLOW_PERIOD  = 32'd500;
  localparam logic [31:0] FAST_PERIOD  = 32'd100;
  localparam logic [31:0] PULSE_PERIOD = 32'd10;
  localparam logic [8:0]  RAMP_STEP    = 9'd5;
  localparam logic [8:0]  RAMP_MAX     = 9'd255;
  localparam logic [7:0]  RAMP_THRESH  = 8'd128;
  localparam logic [9:0]  HB_ON1_END   = 10'd100;
  localparam logic [9:0]  HB_ON2_BEG   = 10'd200;
  localparam logic [9:0]  HB_ON2_END   = 10'd300;
  // 2^32 mod 1000, added back when the elapsed-time subtraction wraps
  localparam logic signed [11:0] WRAP_MOD  = 12'sd296;
  localparam logic signed [11:0] HB_PERIOD = 12'sd1000;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  led_index;
    logic [2:0]  pattern;
    logic [31:0] duration_ms;
    logic        level;
    logic [31:0] now_ms;
    logic [9:0]  now_mod;   // now_ms mod 1000
  } item_t;

  typedef struct packed {
    logic tick;
    logic set_pat;
    logic set_dir;
  } slice_ctrl_t;

  // x mod 1000 by folding bytes with their weights mod 1000
  // (2^8 -> 256, 2^16 -> 536, 2^24 -> 216, 2^10 -> 24).
  function automatic logic [9:0] mod1000(input logic [31:0] x);
    logic [17:0] s1;
    logic [12:0] s2;
    logic [10:0] s3;
    s1 = 18'(x[7:0]) + 18'(x[15:8]) * 18'd256 + 18'(x[23:16]) * 18'd536
       + 18'(x[31:24]) * 18'd216;
    s2 = 13'(s1[9:0]) + 13'(s1[17:10]) * 13'd24;
    s3 = 11'(s2[9:0]) + 11'(s2[12:10]) * 11'd24;
    return (s3 >= 11'd1000) ? 10'(s3 - 11'd1000) : s3[9:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lpe_in_stage.sv =====
// ----------------------------------------------------------------------------
// lpe_in_stage
// Input register: captures one event and its timestamp mod 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [71:0]   in_tdata,
  input  wire logic [1:0]    in_tuser,
  input  wire logic          take,      // downstream consumes the held item
  output logic               hold_valid,
  output lpe_pkg::item_t     item
);

  logic           valid_r, valid_nxt;
  lpe_pkg::item_t item_r,  item_nxt;
  logic           in_fire;

  assign in_tready = !valid_r || take;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_nxt             = item_r;
    valid_nxt            = valid_r;
    if (in_fire) begin
      valid_nxt            = 1'b1;
      item_nxt.action      = in_tuser;
      item_nxt.led_index   = in_tdata[1:0];
      item_nxt.pattern     = in_tdata[4:2];
      item_nxt.duration_ms = in_tdata[36:5];
      item_nxt.level       = in_tdata[37];
      item_nxt.now_ms      = in_tdata[69:38];
      item_nxt.now_mod     = lpe_pkg::mod1000(in_tdata[69:38]);
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign hold_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/lpe_led_slice.sv =====
// ----------------------------------------------------------------------------
// lpe_led_slice
// State and pattern update of one LED.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_led_slice (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lpe_pkg::slice_ctrl_t ctrl,
  input  wire lpe_pkg::item_t       item,
  output logic                      lit_nxt
);

  logic [2:0]  mode_r,   mode_nxt;
  logic        lit_r,    lit_n;
  logic [31:0] start_r,  start_nxt;
  logic [9:0]  smod_r,   smod_nxt;
  logic [31:0] life_r,   life_nxt;
  logic [31:0] last_r,   last_nxt;
  logic [7:0]  ramp_r,   ramp_nxt;
  logic        rise_r,   rise_nxt;

  always_comb begin
    logic                borrow;
    logic [31:0]         since_start;
    logic [31:0]         since_last;
    logic [8:0]          up;
    logic signed [11:0]  d0;
    logic signed [11:0]  d1;
    logic [9:0]          phase;
    logic [7:0]          ramp_new;

    mode_nxt  = mode_r;
    lit_n     = lit_r;
    start_nxt = start_r;
    smod_nxt  = smod_r;
    life_nxt  = life_r;
    last_nxt  = last_r;
    ramp_nxt  = ramp_r;
    rise_nxt  = rise_r;

    {borrow, since_start} = {1'b0, item.now_ms} - {1'b0, start_r};
    since_last            = item.now_ms - last_r;
    up                    = {1'b0, ramp_r} + lpe_pkg::RAMP_STEP;
    ramp_new              = ramp_r;

    // elapsed mod 1000 from the stored residues; wrap adds 2^32 mod 1000
    d0 = $signed({2'b00, item.now_mod}) - $signed({2'b00, smod_r})
       + (borrow ? lpe_pkg::WRAP_MOD : 12'sd0);
    if (d0 < 12'sd0) begin
      d1 = d0 + lpe_pkg::HB_PERIOD;
    end else if (d0 >= lpe_pkg::HB_PERIOD) begin
      d1 = d0 - lpe_pkg::HB_PERIOD;
    end else begin
      d1 = d0;
    end
    phase = d1[9:0];

    priority if (ctrl.set_pat) begin
      mode_nxt  = item.pattern;
      start_nxt = item.now_ms;
      smod_nxt  = item.now_mod;
      life_nxt  = item.duration_ms;
      last_nxt  = item.now_ms;
      ramp_nxt  = 8'd0;
      rise_nxt  = 1'b1;
      if (item.pattern == lpe_pkg::PAT_OFF) begin
        lit_n = 1'b0;
      end else if (item.pattern == lpe_pkg::PAT_ON) begin
        lit_n = 1'b1;
      end
    end else if (ctrl.set_dir) begin
      lit_n    = item.level;
      mode_nxt = item.level ? lpe_pkg::PAT_ON : lpe_pkg::PAT_OFF;
    end else if (ctrl.tick) begin
      if (life_r != 32'd0 && since_start >= life_r) begin
        // lifetime over: forced off, lifetime kept so it stays off
        lit_n    = 1'b0;
        mode_nxt = lpe_pkg::PAT_OFF;
      end else begin
        unique case (mode_r)
          lpe_pkg::PAT_OFF: lit_n = 1'b0;
          lpe_pkg::PAT_ON:  lit_n = 1'b1;
          lpe_pkg::PAT_SLOW, lpe_pkg::PAT_FAST: begin
            if (since_last >= ((mode_r == lpe_pkg::PAT_SLOW) ? lpe_pkg::SLOW_PERIOD
                                                              : lpe_pkg::FAST_PERIOD)) begin
              lit_n    = !lit_r;
              last_nxt = item.now_ms;
            end
          end
          lpe_pkg::PAT_PULSE: begin
            if (since_last >= lpe_pkg::PULSE_PERIOD) begin
              if (rise_r) begin
                if (up >= lpe_pkg::RAMP_MAX) begin
                  ramp_new = 8'hFF;
                  rise_nxt = 1'b0;
                end else begin
                  ramp_new = up[7:0];
                end
              end else begin
                if (ramp_r <= 8'(lpe_pkg::RAMP_STEP)) begin
                  ramp_new = 8'd0;
                  rise_nxt = 1'b1;
                end else begin
                  ramp_new = ramp_r - 8'(lpe_pkg::RAMP_STEP);
                end
              end
              ramp_nxt = ramp_new;
              lit_n    = (ramp_new > lpe_pkg::RAMP_THRESH);
              last_nxt = item.now_ms;
            end
          end
          lpe_pkg::PAT_HEART: begin
            lit_n = (phase < lpe_pkg::HB_ON1_END) ||
                    (phase >= lpe_pkg::HB_ON2_BEG && phase < lpe_pkg::HB_ON2_END);
          end
          default: ;
        endcase
      end
    end else begin
      lit_n = lit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lpe_pkg::PAT_OFF;
      lit_r   <= 1'b0;
      start_r <= 32'd0;
      smod_r  <= 10'd0;
      life_r  <= 32'd0;
      last_r  <= 32'd0;
      ramp_r  <= 8'd0;
      rise_r  <= 1'b1;
    end else begin
      mode_r  <= mode_nxt;
      lit_r   <= lit_n;
      start_r <= start_nxt;
      smod_r  <= smod_nxt;
      life_r  <= life_nxt;
      last_r  <= last_nxt;
      ramp_r  <= ramp_nxt;
      rise_r  <= rise_nxt;
    end
  end

  assign lit_nxt = lit_n;

endmodule

`default_nettype wire

// ===== rtl/led_pattern_engine_unit.sv =====
// ----------------------------------------------------------------------------
// led_pattern_engine_unit
// Pattern engine for indicator LEDs driven by timestamped events.
// ----------------------------------------------------------------------------
// Each input transaction is one event (tick, set pattern, direct on/off) with
// a millisecond timestamp, and each produces exactly one output transaction
// carrying the lit state of LEDs 0..3 after the event. The engine takes one
// transaction per clock while out_tready stays high: an input register holds
// the event, all LED slices update from it in a single combinational pass
// once the output register is free, and the result lands in the output
// register, which drives out_tvalid. While a result is stalled on out_tready,
// one more event waits in the input register and in_tready then drops. The
// heartbeat phase uses the timestamp mod 1000, folded at input capture and
// kept per LED from the pattern start.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pattern_engine_unit_defines.svh"

module led_pattern_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Event stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] led_index, [4:2] pattern, [36:5] duration_ms, [37] level,
  // [69:38] now_ms, [71:70] zero
  input  wire logic [71:0] in_tdata,
  // [1:0] action
  input  wire logic [1:0]  in_tuser,
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] led_lit_bits, [7:4] zero
  output logic [7:0]       out_tdata
);

  logic                 hold_valid;
  lpe_pkg::item_t       item;
  logic                 take;        // held event processed this cycle
  logic                 out_free;
  logic [lpe_pkg::NUM_LEDS-1:0] lit_vec;
  logic [lpe_pkg::LIT_W-1:0]    lit_pad;

  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_bits_r,  out_bits_nxt;

  // Output register frees up in the same cycle its transaction completes
  assign out_free = !out_valid_r || out_tready;
  assign take     = hold_valid && out_free;

  lpe_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .hold_valid (hold_valid),
    .item       (item)
  );

  // One slice per LED; set events go only to the addressed one
  for (genvar g = 0; g < lpe_pkg::NUM_LEDS; g++) begin : g_led
    lpe_pkg::slice_ctrl_t ctrl;
    logic                 hit;

    assign hit          = (32'(item.led_index) == 32'(g));
    assign ctrl.tick    = take && (item.action == lpe_pkg::ACT_TICK);
    assign ctrl.set_pat = take && hit && (item.action == lpe_pkg::ACT_SET_PAT);
    assign ctrl.set_dir = take && hit && (item.action == lpe_pkg::ACT_SET_DIR);

    lpe_led_slice u_slice (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .item    (item),
      .lit_nxt (lit_vec[g])
    );
  end

  // Only LEDs 0..3 are reported; missing ones read as dark
  assign lit_pad = lpe_pkg::LIT_W'(lit_vec);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bits_nxt  = out_bits_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_bits_nxt  = lit_pad[3:0];
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bits_r <= out_bits_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_bits_r};

  // Every processed event yields a result in the next cycle
  `LPE_ASSERT_NEXT(a_take_gives_result, take, out_tvalid)
  // Input back-pressure only when both registers are full and output stalled
  `LPE_ASSERT_SAME(a_stall_cause, !in_tready, hold_valid && out_valid_r && !out_tready)
  // A direct set shows up on its LED bit in the matching result
  `LPE_ASSERT_NEXT(a_direct_set_seen,
    take && item.action == lpe_pkg::ACT_SET_DIR,
    out_bits_r[$past(item.led_index)] == $past(item.level))

endmodule

`default_nettype wire

// ===== tb/led_pattern_engine_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_pattern_engine_unit_checker
// Watches both streams, predicts the lit vector of every event and compares.
// ----------------------------------------------------------------------------
module led_pattern_engine_unit_checker
  import lpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          mismatch_count,
  output int          pending_count
);

  // Per-LED shadow state
  logic [2:0]  led_mode   [NUM_LEDS];
  logic        led_lit    [NUM_LEDS];
  logic [31:0] pat_start  [NUM_LEDS];
  logic [31:0] pat_life   [NUM_LEDS];
  logic [31:0] step_stamp [NUM_LEDS];
  logic [7:0]  ramp_lvl   [NUM_LEDS];
  logic        ramp_up    [NUM_LEDS];

  logic [3:0]  lit_expect_q [$];
  int          fail_tally = 0;

  // Applies one event to the shadow LEDs and returns the lit vector after it.
  task automatic step_led_engine(input logic [1:0] act, input logic [1:0] idx,
                                 input logic [2:0] pat, input logic [31:0] dur,
                                 input logic lvl, input logic [31:0] stamp,
                                 output logic [3:0] lit_vec);
    logic [31:0] since_start;
    logic [31:0] since_step;
    logic [31:0] period;
    logic [31:0] hb_phase;
    logic [8:0]  ramp_sum;
    case (act)
      ACT_TICK: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          since_start = stamp - pat_start[i];
          since_step  = stamp - step_stamp[i];
          // expired lifetime acts as a direct off and nothing else
          if (pat_life[i] != 32'd0 && since_start >= pat_life[i]) begin
            led_lit[i]  = 1'b0;
            led_mode[i] = PAT_OFF;
          end else begin
            case (led_mode[i])
              PAT_OFF: led_lit[i] = 1'b0;
              PAT_ON:  led_lit[i] = 1'b1;
              PAT_SLOW, PAT_FAST: begin
                period = (led_mode[i] == PAT_SLOW) ? SLOW_PERIOD : FAST_PERIOD;
                if (since_step >= period) begin
                  led_lit[i]    = ~led_lit[i];
                  step_stamp[i] = stamp;
                end
              end
              PAT_PULSE: begin
                if (since_step >= PULSE_PERIOD) begin
                  if (ramp_up[i]) begin
                    ramp_sum = {1'b0, ramp_lvl[i]} + RAMP_STEP;
                    if (ramp_sum >= RAMP_MAX) begin
                      ramp_sum   = RAMP_MAX;
                      ramp_up[i] = 1'b0;
                    end
                    ramp_lvl[i] = ramp_sum[7:0];
                  end else if ({1'b0, ramp_lvl[i]} <= RAMP_STEP) begin
                    ramp_lvl[i] = 8'd0;
                    ramp_up[i]  = 1'b1;
                  end else begin
                    ramp_lvl[i] = ramp_lvl[i] - RAMP_STEP[7:0];
                  end
                  led_lit[i]    = (ramp_lvl[i] > RAMP_THRESH);
                  step_stamp[i] = stamp;
                end
              end
              PAT_HEART: begin
                hb_phase   = since_start % 32'(HB_PERIOD);
                led_lit[i] = (hb_phase < 32'(HB_ON1_END)) ||
                             (hb_phase >= 32'(HB_ON2_BEG) && hb_phase < 32'(HB_ON2_END));
              end
              default: ;  // spare codes hold the LED as it is
            endcase
          end
        end
      end
      ACT_SET_PAT: begin
        if (int'(idx) < NUM_LEDS) begin
          led_mode[idx]   = pat;
          pat_start[idx]  = stamp;
          pat_life[idx]   = dur;
          step_stamp[idx] = stamp;
          ramp_lvl[idx]   = 8'd0;
          ramp_up[idx]    = 1'b1;
          if (pat == PAT_OFF) led_lit[idx] = 1'b0;
          else if (pat == PAT_ON) led_lit[idx] = 1'b1;
        end
      end
      ACT_SET_DIR: begin
        if (int'(idx) < NUM_LEDS) begin
          led_lit[idx]  = lvl;
          led_mode[idx] = lvl ? PAT_ON : PAT_OFF;
        end
      end
      default: ;
    endcase
    lit_vec = 4'd0;
    for (int i = 0; i < NUM_LEDS && i < 4; i++) lit_vec[i] = led_lit[i];
  endtask

  always @(posedge clk) begin
    logic [3:0] lit_vec;
    logic [3:0] want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode[i]   = PAT_OFF;
        led_lit[i]    = 1'b0;
        pat_start[i]  = 32'd0;
        pat_life[i]   = 32'd0;
        step_stamp[i] = 32'd0;
        ramp_lvl[i]   = 8'd0;
        ramp_up[i]    = 1'b1;
      end
      lit_expect_q.delete();
    end else begin
      // results leave only after their event passes the input and output registers, so pop first
      if (out_tvalid && out_tready) begin
        if (lit_expect_q.size() == 0) begin
          $error("unexpected result transaction: led_lit_bits actual %b", out_tdata[3:0]);
          fail_tally++;
        end else begin
          want = lit_expect_q.pop_front();
          if (out_tdata[3:0] !== want) begin
            $error("led_lit_bits mismatch: expected %b, actual %b", want, out_tdata[3:0]);
            fail_tally++;
          end
          if (out_tdata[7:4] !== 4'd0) begin
            $error("out_tdata pad mismatch: expected %h, actual %h", 4'd0, out_tdata[7:4]);
            fail_tally++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        step_led_engine(in_tuser, in_tdata[1:0], in_tdata[4:2], in_tdata[36:5],
                        in_tdata[37], in_tdata[69:38], lit_vec);
        lit_expect_q.push_back(lit_vec);
      end
    end
    mismatch_count <= fail_tally;
    pending_count  <= lit_expect_q.size();
  end

endmodule

// ===== tb/led_pattern_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_pattern_engine_unit_tb
// Drives timestamped LED events into the engine and judges the lit results.
// ----------------------------------------------------------------------------
// A short directed sequence walks every event kind and pattern, lifetime
// expiry (including across the 32-bit timestamp wrap), heartbeat phases and
// the spare codes. Random traffic follows: mostly ticks with small time steps
// so blink, pulse and heartbeat patterns run through their cycles, with
// segments of sparse and dense pattern changes. The checker beside the block
// predicts and compares; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module led_pattern_engine_unit_tb;
  import lpe_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 10;      // drain margin after the last result
  localparam int HOLD_AT      = 400;     // results seen before the long stall
  localparam int HOLD_CYCLES  = 300;
  // codes the engine stores but never acts on
  localparam logic [2:0] PAT_SPARE_LO = 3'd6;
  localparam logic [2:0] PAT_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [1:0] led_index, [4:2] pattern, [36:5] duration_ms, [37] level,
  // [69:38] now_ms, [71:70] zero
  logic [71:0] in_tdata;
  // [1:0] action
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // [3:0] led_lit_bits, [7:4] zero
  logic [7:0]  out_tdata;

  int          mismatch_count;
  int          pending_count;
  int          cycle_count;
  logic        steady;        // sender skips its idle cycles while set
  logic [31:0] now_ms_cur;    // running millisecond clock of the stimulus

  led_pattern_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  led_pattern_engine_unit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offer one event and hold it until the transaction completes. Valid stays
  // high into the next call unless that call opens with an idle gap, so it
  // gets at most one update per edge.
  task automatic send_event(input logic [1:0] act, input logic [1:0] idx,
                            input logic [2:0] pat, input logic [31:0] dur,
                            input logic lvl, input logic [31:0] stamp);
    if (!steady && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, stamp, lvl, dur, pat, idx};
    // in_tready read right after the edge still holds its pre-edge value
    do @(posedge clk); while (!in_tready);
  endtask

  // Receiver: random backpressure, one long hold-off so the block fills and
  // stalls its input, and a stretch of steady acceptance.
  initial begin
    int  results_seen;
    int  hold_left;
    bit  held;
    results_seen = 0;
    hold_left    = 0;
    held         = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) results_seen++;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (results_seen >= HOLD_AT && !held) begin
        held       = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (results_seen >= 700 && results_seen < 1000) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int          sent;
    int          set_pct;
    int          r;
    logic [1:0]  act;
    logic [2:0]  pat;
    logic [31:0] dur;

    steady     = 1'b0;
    now_ms_cur = 32'd0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_TICK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // unknown action with every field but the timestamp at its top value: no state change
    send_event(ACT_NONE, 2'd3, PAT_SPARE_HI, 32'hFFFF_FFFF, 1'b1, 32'd0);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd0);
    send_event(ACT_SET_PAT, 2'd0, PAT_ON, 32'd0, 1'b0, 32'd10);
    send_event(ACT_SET_PAT, 2'd1, PAT_SLOW, 32'd0, 1'b0, 32'd10);
    send_event(ACT_SET_PAT, 2'd2, PAT_FAST, 32'd250, 1'b0, 32'd10);
    send_event(ACT_SET_PAT, 2'd3, PAT_PULSE, 32'd0, 1'b0, 32'd10);
    // fast toggles and pulse steps; then slow toggles while fast has expired
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd110);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd510);
    // heartbeat: lit, dark, lit across its first window
    send_event(ACT_SET_PAT, 2'd0, PAT_HEART, 32'd0, 1'b0, 32'd1000);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd1050);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd1150);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd1250);
    // direct on / off keep the stored lifetime
    send_event(ACT_SET_DIR, 2'd1, PAT_OFF, 32'd0, 1'b1, 32'd1300);
    send_event(ACT_SET_DIR, 2'd3, PAT_OFF, 32'd0, 1'b0, 32'd1300);
    // spare pattern codes hold the LED on ticks; lifetime of one expires
    // exactly when elapsed time equals it
    send_event(ACT_SET_PAT, 2'd2, PAT_SPARE_LO, 32'd0, 1'b0, 32'd1400);
    send_event(ACT_SET_PAT, 2'd3, PAT_SPARE_HI, 32'd1, 1'b0, 32'd1500);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd1500);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'd1501);
    // lifetime and heartbeat phase across the timestamp wrap
    send_event(ACT_SET_PAT, 2'd1, PAT_OFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF0);
    send_event(ACT_SET_PAT, 2'd0, PAT_HEART, 32'd32, 1'b0, 32'hFFFF_FFF0);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'h0000_000F);
    send_event(ACT_TICK, 2'd0, PAT_OFF, 32'd0, 1'b0, 32'h0000_0010);
    send_event(ACT_SET_DIR, 2'd2, PAT_OFF, 32'd0, 1'b1, 32'h0000_0020);
    send_event(ACT_SET_PAT, 2'd2, PAT_ON, 32'd0, 1'b0, 32'h0000_0020);
    now_ms_cur = 32'h0000_0030;

    // ---- random ----
    sent    = 0;
    set_pct = 10;
    while (sent < RANDOM_ITEMS) begin
      // pattern-change density varies per segment; sparse segments let
      // pulse ramps run all the way up and down
      if (sent % 150 == 0) begin
        r = $urandom_range(2);
        set_pct = (r == 0) ? 2 : (r == 1) ? 10 : 30;
      end
      steady = (sent >= 700 && sent < 1000);

      r = $urandom_range(99);
      if (r < 80)      now_ms_cur = now_ms_cur + $urandom_range(0, 25);
      else if (r < 95) now_ms_cur = now_ms_cur + $urandom_range(0, 1200);
      else if (r < 97) now_ms_cur = $urandom;
      else if (r < 98) now_ms_cur = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else             now_ms_cur = now_ms_cur - $urandom_range(0, 50);

      r = $urandom_range(99);
      if (r < set_pct)          act = ACT_SET_PAT;
      else if (r < set_pct + 5) act = ACT_SET_DIR;
      else if (r < set_pct + 8) act = ACT_NONE;
      else                      act = ACT_TICK;

      pat = ($urandom_range(99) < 80) ? 3'($urandom_range(5)) : 3'($urandom_range(7));
      r = $urandom_range(99);
      if (r < 50)      dur = 32'd0;
      else if (r < 75) dur = $urandom_range(1, 4000);
      else if (r < 90) dur = $urandom;
      else if (r < 95) dur = 32'd1;
      else             dur = 32'hFFFF_FFFF;
      // fields an event does not use still carry random content
      if (act != ACT_SET_PAT && $urandom_range(1) == 1) dur = $urandom;

      send_event(act, 2'($urandom_range(3)), pat, dur, 1'($urandom_range(1)), now_ms_cur);
      if (act != ACT_NONE) sent++;
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    // drain, then give the pipeline time to show any stray result
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpe_pkg.sv
rtl/lpe_in_stage.sv
rtl/lpe_led_slice.sv
rtl/led_pattern_engine_unit.sv
tb/led_pattern_engine_unit_checker.sv
tb/led_pattern_engine_unit_tb.sv
